[rtl/shb_pkg.sv]
// Shared types, constants and helper functions of the SHA-256 byte stream hasher.
// Depends on nothing; used by the round unit and the top level.
`timescale 1ns / 1ps

package shb_pkg;

	localparam int unsigned BUF_DEPTH   = 16;
	localparam int unsigned CHAIN_DEPTH = 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PADI,
		S_PAD,
		S_LOAD,
		S_RND,
		S_FEED,
		S_DRD,
		S_DLD
	} shb_state_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
		logic [31:0] f;
		logic [31:0] g;
		logic [31:0] h;
	} shb_vars_t;

	localparam logic [31:0] PAD_MARK = 32'h8000_0000;
	localparam logic [5:0]  LAST_BYTE_POS = 6'd63;
	localparam logic [5:0]  LAST_ROUND = 6'd63;

	localparam logic [31:0] H_INIT [CHAIN_DEPTH] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

[rtl/shb_round.sv]
// One SHA-256 compression round on the eight working variables.
// Depends on shb_pkg for the variable struct and the sigma functions.
`timescale 1ns / 1ps

module shb_round import shb_pkg::*; (
	input  shb_vars_t   cur,
	input  logic [31:0] w,
	input  logic [31:0] k,
	output shb_vars_t   nxt
);

	logic [31:0] ch;
	logic [31:0] mj;
	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		ch = (cur.e & cur.f) ^ (~cur.e & cur.g);
		mj = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
		t1 = cur.h + big_sigma1(cur.e) + ch + k + w;
		t2 = big_sigma0(cur.a) + mj;
		nxt.h = cur.g;
		nxt.g = cur.f;
		nxt.f = cur.e;
		nxt.e = cur.d + t1;
		nxt.d = cur.c;
		nxt.c = cur.b;
		nxt.b = cur.a;
		nxt.a = t1 + t2;
	end

endmodule

[rtl/sha256_byte_stream_hasher_top.sv]
// Top level of the SHA-256 byte stream hasher: byte packing, padding, schedule and control.
// Depends on shb_pkg and shb_round.
`timescale 1ns / 1ps

// Message bytes are taken one item per cycle while the block is idle. The item that
// completes a 64-byte block starts a compression (loading the chaining words from
// their memory, 64 rounds at one round per cycle, adding the result back into the
// chaining memory), during which in_ready is low. An end item adds padding into the
// block buffer memory (a second padded block when the length field needs one), one or
// two compressions, and then the digest words, which come out in order from index 0
// to 7. The output register lets the last word wait while the next message already
// streams in.
module sha256_byte_stream_hasher_top import shb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        final_word
);

	shb_state_t state_q, state_d;
	logic [5:0]  cnt_q, cnt_d;
	logic [63:0] count_q;
	logic [23:0] acc_q;
	logic        eom_pend_q;
	logic        fin_q;
	logic        pad2_q;
	logic        mark_q;
	logic        len_q;
	logic [CHAIN_DEPTH-1:0] chain_vld_q;
	logic        out_vld_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_idx_q;

	shb_vars_t   vars_q;
	shb_vars_t   vars_nxt;
	logic [31:0] w_q;
	logic [31:0] win_q [BUF_DEPTH];
	logic [31:0] sched;

	logic [31:0] buf_mem [BUF_DEPTH];
	logic [31:0] buf_rd_s1;
	logic        buf_we;
	logic [3:0]  buf_wa;
	logic [31:0] buf_wd;
	logic [3:0]  buf_ra;

	logic [31:0] chain_mem [CHAIN_DEPTH];
	logic [31:0] chain_rd_s1;
	logic        chain_vld_s1;
	logic [2:0]  chain_addr_s1;
	logic [31:0] chain_rd;
	logic        chain_we;
	logic [2:0]  chain_wa;
	logic [31:0] chain_wd;
	logic [2:0]  chain_ra;

	logic        in_acc;
	logic [5:0]  pos;
	logic        blk_full;
	logic        out_free;
	logic [31:0] mark_word;

	assign in_ready    = (state_q == S_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign pos         = count_q[5:0];
	assign blk_full    = has_byte && (pos == LAST_BYTE_POS);
	assign out_free    = !out_vld_q || out_ready;
	assign out_valid   = out_vld_q;
	assign digest_word = out_word_q;
	assign word_index  = out_idx_q;
	assign final_word  = (out_idx_q == 3'd7);
	assign chain_rd    = chain_vld_s1 ? chain_rd_s1 : H_INIT[chain_addr_s1];

	assign sched = win_q[1] + small_sigma0(win_q[2]) + win_q[10] + small_sigma1(win_q[15]);

	shb_round u_round (
		.cur (vars_q),
		.w   (w_q),
		.k   (ROUND_K[cnt_q]),
		.nxt (vars_nxt)
	);

	always_comb begin
		case (pos[1:0])
			2'd0:    mark_word = PAD_MARK;
			2'd1:    mark_word = {acc_q[23:16], PAD_MARK[31:8]};
			2'd2:    mark_word = {acc_q[23:8], PAD_MARK[31:16]};
			default: mark_word = {acc_q, PAD_MARK[31:24]};
		endcase
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		buf_we   = 1'b0;
		buf_wa   = cnt_q[3:0];
		buf_wd   = '0;
		buf_ra   = cnt_q[3:0] + 4'd2;
		chain_ra = cnt_q[2:0];
		chain_we = 1'b0;
		chain_wa = cnt_q[2:0] - 3'd1;
		chain_wd = chain_rd + vars_q.a;
		case (state_q)
			S_IDLE: begin
				if (in_acc && has_byte && (pos[1:0] == 2'd3)) begin
					buf_we = 1'b1;
					buf_wa = pos[5:2];
					buf_wd = {acc_q, data_byte};
				end
				if (in_acc && blk_full) begin
					state_d = S_LOAD;
					cnt_d   = '0;
				end else if (in_acc && end_of_message) begin
					state_d = S_PADI;
				end
			end
			S_PADI: begin
				state_d = S_PAD;
				cnt_d   = {2'b00, pos[5:2]};
			end
			S_PAD: begin
				buf_we = 1'b1;
				if (mark_q) begin
					buf_wd = mark_word;
				end else if (len_q && (cnt_q[3:0] == 4'd14)) begin
					buf_wd = count_q[60:29];
				end else if (len_q && (cnt_q[3:0] == 4'd15)) begin
					buf_wd = {count_q[28:0], 3'b000};
				end
				if (cnt_q[3:0] == 4'd15) begin
					state_d = S_LOAD;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_LOAD: begin
				buf_ra = (cnt_q == 6'd8) ? 4'd1 : 4'd0;
				if (cnt_q == 6'd8) begin
					state_d = S_RND;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_RND: begin
				if (cnt_q == LAST_ROUND) begin
					state_d = S_FEED;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_FEED: begin
				chain_we = (cnt_q != 6'd0);
				if (cnt_q == 6'd8) begin
					cnt_d = '0;
					if (fin_q) begin
						state_d = S_DRD;
					end else if (pad2_q) begin
						state_d = S_PAD;
					end else if (eom_pend_q) begin
						state_d = S_PADI;
					end else begin
						state_d = S_IDLE;
					end
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_DRD: begin
				if (out_free) begin
					state_d = S_DLD;
				end
			end
			S_DLD: begin
				if (cnt_q[2:0] == 3'd7) begin
					state_d = S_IDLE;
					cnt_d   = '0;
				end else begin
					state_d = S_DRD;
					cnt_d   = cnt_q + 6'd1;
				end
			end
			default: begin
				state_d = S_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			count_q     <= '0;
			eom_pend_q  <= 1'b0;
			fin_q       <= 1'b0;
			pad2_q      <= 1'b0;
			mark_q      <= 1'b0;
			len_q       <= 1'b0;
			chain_vld_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (in_acc) begin
				if (has_byte) begin
					count_q <= count_q + 64'd1;
				end
				eom_pend_q <= blk_full && end_of_message;
			end
			if (state_q == S_PADI) begin
				mark_q <= 1'b1;
				len_q  <= (pos[5:3] != 3'b111);
			end
			if (state_q == S_PAD) begin
				mark_q <= 1'b0;
				if (cnt_q[3:0] == 4'd15) begin
					fin_q  <= len_q;
					pad2_q <= !len_q;
				end
			end
			if ((state_q == S_FEED) && (cnt_q == 6'd8) && !fin_q) begin
				if (pad2_q) begin
					pad2_q <= 1'b0;
					mark_q <= 1'b0;
					len_q  <= 1'b1;
				end else begin
					eom_pend_q <= 1'b0;
				end
			end
			if (chain_we) begin
				chain_vld_q[chain_wa] <= 1'b1;
			end
			if ((state_q == S_DLD) && (cnt_q[2:0] == 3'd7)) begin
				count_q     <= '0;
				chain_vld_q <= '0;
				fin_q       <= 1'b0;
			end
			if (state_q == S_DLD) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && has_byte) begin
			case (pos[1:0])
				2'd0:    acc_q[23:16] <= data_byte;
				2'd1:    acc_q[15:8]  <= data_byte;
				2'd2:    acc_q[7:0]   <= data_byte;
				default: acc_q        <= acc_q;
			endcase
		end
		case (state_q)
			S_LOAD: begin
				if (cnt_q != 6'd0) begin
					vars_q <= {vars_q.b, vars_q.c, vars_q.d, vars_q.e,
						vars_q.f, vars_q.g, vars_q.h, chain_rd};
				end
				if (cnt_q == 6'd8) begin
					w_q <= buf_rd_s1;
				end
			end
			S_RND: begin
				vars_q <= vars_nxt;
				w_q    <= (cnt_q < 6'd15) ? buf_rd_s1 : sched;
				for (int i = 0; i < BUF_DEPTH - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[BUF_DEPTH-1] <= w_q;
			end
			S_FEED: begin
				if (cnt_q != 6'd0) begin
					vars_q <= {vars_q.b, vars_q.c, vars_q.d, vars_q.e,
						vars_q.f, vars_q.g, vars_q.h, vars_q.a};
				end
			end
			S_DLD: begin
				out_word_q <= chain_rd;
				out_idx_q  <= cnt_q[2:0];
			end
			default: begin
				w_q <= w_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[buf_wa] <= buf_wd;
		end
		buf_rd_s1 <= buf_mem[buf_ra];
	end

	always_ff @(posedge clk) begin
		if (chain_we) begin
			chain_mem[chain_wa] <= chain_wd;
		end
		chain_rd_s1   <= chain_mem[chain_ra];
		chain_vld_s1  <= chain_vld_q[chain_ra];
		chain_addr_s1 <= chain_ra;
	end

endmodule

[rtl/shb_checker.sv]
// Port-level assertions for the SHA-256 byte stream hasher, bound to its top level.
// Depends on sha256_byte_stream_hasher_top.
`timescale 1ns / 1ps

module shb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        end_of_message,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        final_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
		else $error("Stalled digest item changed or dropped.");

	a_final_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (final_word == (word_index == 3'd7)))
		else $error("final_word disagrees with word_index.");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_message |=> !in_ready)
		else $error("Input taken right after an end item.");

	a_digest_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !final_word |=> !in_ready)
		else $error("Input taken before the digest was complete.");

endmodule

bind sha256_byte_stream_hasher_top shb_checker u_shb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.end_of_message (end_of_message),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.digest_word    (digest_word),
	.word_index     (word_index),
	.final_word     (final_word)
);
